// ----- src/cef_pkg.sv -----
// ----------------------------------------------------------------------------
// cef_pkg
// Shared types and constants of the changed extent finder: extent records,
// queue entries and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cef_pkg;

   // default width of position and length counters
   localparam int OFFSET_BITS_DEFAULT = 32;

   // width of offset and length on the result channel
   localparam int EXTENT_WIDTH = 32;

   // width of the minimum run length register
   localparam int MIN_RUN_WIDTH = 16;

   // minimum run length after reset
   localparam logic [MIN_RUN_WIDTH-1:0] MIN_RUN_RESET = 16'd512;

   // entries in the queue between classifier and emitter
   localparam int QUEUE_DEPTH = 4;

   // one extent as delivered on the result channel
   typedef struct packed {
      logic [EXTENT_WIDTH-1:0] offset;
      logic [EXTENT_WIDTH-1:0] length;
   } extent_type;

   // all extents caused by one input transaction (one or two)
   typedef struct packed {
      logic       two;
      extent_type first;
      extent_type second;
   } entry_type;

endpackage

`default_nettype wire

// ----- src/changed_extent_finder_top.sv -----
// Flow: an extent is written to the queue in the cycle its req transaction is
//   accepted and goes out on the rsp channel from the registered queue head.
// Throughput: one req transaction per cycle while the queue has room; a
//   two-extent transaction sends both in turn, buffered by the four-entry queue.
// Reset: synchronous; clears position, run, tail and queue, and sets the
//   minimum run length to 512.
// ----------------------------------------------------------------------------
// changed_extent_finder_top
// Streams byte pairs of old and new image and reports the extents of the new
// image that must be rewritten.
// ----------------------------------------------------------------------------
`default_nettype none

module changed_extent_finder_top #(
   parameter int OFFSET_BITS = cef_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // byte pair transactions
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_old_byte,
   input  wire logic [7:0]                          req_new_byte,
   input  wire logic                                req_has_old,
   input  wire logic                                req_last_position,
   // extent transactions
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [cef_pkg::EXTENT_WIDTH-1:0]         rsp_extent_offset,
   output logic [cef_pkg::EXTENT_WIDTH-1:0]         rsp_extent_length,
   output logic                                     rsp_last_of_item,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cef_pkg::MIN_RUN_WIDTH-1:0]   csr_min_run_length
);
   import cef_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // classifier
   cef_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_old_byte      (req_old_byte),
      .req_new_byte      (req_new_byte),
      .req_has_old       (req_has_old),
      .req_last_position (req_last_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_min_run_length(csr_min_run_length),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   // decoupling queue
   cef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   // emitter
   cef_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_extent_offset(rsp_extent_offset),
      .rsp_extent_length(rsp_extent_length),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

`default_nettype wire

// ----- src/cef_front.sv -----
// ----------------------------------------------------------------------------
// cef_front
// Classifier: tracks position, mismatch run and tail, and turns each byte
// pair into zero, one or two extents for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cef_front #(
   parameter int OFFSET_BITS = cef_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input transactions
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_old_byte,
   input  wire logic [7:0]                      req_new_byte,
   input  wire logic                            req_has_old,
   input  wire logic                            req_last_position,
   // configuration
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cef_pkg::MIN_RUN_WIDTH-1:0] csr_min_run_length,
   // toward the queue
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output cef_pkg::entry_type                   push_entry
);
   import cef_pkg::*;

   localparam int CMP_W = (OFFSET_BITS > MIN_RUN_WIDTH) ? OFFSET_BITS : MIN_RUN_WIDTH;

   logic [MIN_RUN_WIDTH-1:0] min_run_ff;
   logic [OFFSET_BITS-1:0]   position_ff, position_in;
   logic                     run_open_ff, run_open_in;
   logic [OFFSET_BITS-1:0]   run_start_ff, run_start_in;
   logic                     tail_open_ff, tail_open_in;
   logic [OFFSET_BITS-1:0]   tail_start_ff, tail_start_in;

   logic accept;
   logic [1:0] ext_cnt;
   extent_type ext0, ext1;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MIN_RUN_RESET;
      end else if (csr_valid && csr_ready) begin
         min_run_ff <= csr_min_run_length;
      end
   end

   // classify the byte pair and collect extents
   always_comb begin
      logic [OFFSET_BITS-1:0] p;
      logic [OFFSET_BITS-1:0] p_next;
      logic [OFFSET_BITS-1:0] run_len;
      logic                   match;
      logic                   r_open;
      logic [OFFSET_BITS-1:0] r_start;
      logic                   t_open;
      logic [OFFSET_BITS-1:0] t_start;

      p       = position_ff;
      p_next  = p + OFFSET_BITS'(1);
      run_len = p - run_start_ff;
      match   = (req_old_byte == req_new_byte);
      r_open  = run_open_ff;
      r_start = run_start_ff;
      t_open  = tail_open_ff;
      t_start = tail_start_ff;
      ext_cnt = 2'd0;
      ext0    = '0;
      ext1    = '0;

      if (req_has_old && !t_open) begin
         // old data present: close run on a match once long enough
         if (r_open) begin
            if (match && (CMP_W'(run_len) >= CMP_W'(min_run_ff))) begin
               ext0.offset = EXTENT_WIDTH'(r_start);
               ext0.length = EXTENT_WIDTH'(run_len);
               ext_cnt     = 2'd1;
               r_open      = 1'b0;
            end
         end else if (!match) begin
            r_open  = 1'b1;
            r_start = p;
         end
      end else begin
         // old data ended: close run, open tail
         if (r_open) begin
            ext0.offset = EXTENT_WIDTH'(r_start);
            ext0.length = EXTENT_WIDTH'(run_len);
            ext_cnt     = 2'd1;
            r_open      = 1'b0;
         end
         if (!t_open) begin
            t_open  = 1'b1;
            t_start = p;
         end
      end

      position_in   = p_next;
      run_open_in   = r_open;
      run_start_in  = r_start;
      tail_open_in  = t_open;
      tail_start_in = t_start;

      // final position: flush run and tail, restart at offset zero
      if (req_last_position) begin
         if (r_open) begin
            // a run here never follows an extent of this transaction
            ext0.offset = EXTENT_WIDTH'(r_start);
            ext0.length = EXTENT_WIDTH'(p_next - r_start);
            ext_cnt     = 2'd1;
         end
         if (t_open) begin
            if (ext_cnt == 2'd0) begin
               ext0.offset = EXTENT_WIDTH'(t_start);
               ext0.length = EXTENT_WIDTH'(p_next - t_start);
               ext_cnt     = 2'd1;
            end else begin
               ext1.offset = EXTENT_WIDTH'(t_start);
               ext1.length = EXTENT_WIDTH'(p_next - t_start);
               ext_cnt     = 2'd2;
            end
         end
         position_in   = '0;
         run_open_in   = 1'b0;
         run_start_in  = '0;
         tail_open_in  = 1'b0;
         tail_start_in = '0;
      end
   end

   // queue write
   assign push_valid        = accept && (ext_cnt != 2'd0);
   assign push_entry.two    = (ext_cnt == 2'd2);
   assign push_entry.first  = ext0;
   assign push_entry.second = ext1;

   // tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         run_open_ff   <= 1'b0;
         run_start_ff  <= '0;
         tail_open_ff  <= 1'b0;
         tail_start_ff <= '0;
      end else if (accept) begin
         position_ff   <= position_in;
         run_open_ff   <= run_open_in;
         run_start_ff  <= run_start_in;
         tail_open_ff  <= tail_open_in;
         tail_start_ff <= tail_start_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/cef_queue.sv -----
// ----------------------------------------------------------------------------
// cef_queue
// Short FIFO of extent entries between classifier and emitter, so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cef_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire cef_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output cef_pkg::entry_type      pop_entry
);
   import cef_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/cef_back.sv -----
// ----------------------------------------------------------------------------
// cef_back
// Emitter: takes queue entries and sends their one or two extents on the
// result channel, marking the last extent of each input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cef_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire cef_pkg::entry_type                pop_entry,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [cef_pkg::EXTENT_WIDTH-1:0]       rsp_extent_offset,
   output logic [cef_pkg::EXTENT_WIDTH-1:0]       rsp_extent_length,
   output logic                                   rsp_last_of_item
);
   import cef_pkg::*;

   logic       second_ff, second_in;
   logic       rsp_take;
   extent_type cur;

   assign rsp_valid         = pop_valid;
   assign rsp_take          = rsp_valid && rsp_ready;
   assign cur               = second_ff ? pop_entry.second : pop_entry.first;
   assign rsp_extent_offset = cur.offset;
   assign rsp_extent_length = cur.length;
   assign rsp_last_of_item  = !pop_entry.two || second_ff;

   // release the entry once its last extent is taken
   assign pop_ready = rsp_ready && rsp_last_of_item;

   // which extent of the head entry goes out next
   always_comb begin
      second_in = second_ff;
      if (rsp_take) begin
         second_in = !rsp_last_of_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/changed_extent_finder_top_test.sv -----
// ----------------------------------------------------------------------------
// changed_extent_finder_top_test
// Self-checking bench for the changed extent finder. Byte pair transactions
// stream in from a queue with random gaps while the extent channel stalls at
// random, including one long hold-off that backs the block up. Each accepted
// byte pair runs through a local extent predictor, and every extent
// transaction is checked field by field against the oldest prediction. The
// minimum run length register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module changed_extent_finder_top_test;

   localparam int W = cef_pkg::EXTENT_WIDTH;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [7:0] old_byte;
      logic [7:0] new_byte;
      logic       has_old;
      logic       last_position;
   } byte_pair_type;

   typedef struct {
      logic [W-1:0] offset;
      logic [W-1:0] length;
      logic         last;
   } extent_record_type;

   logic clock;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_old_byte = '0;
   logic [7:0] req_new_byte = '0;
   logic       req_has_old = 1'b0;
   logic       req_last_position = 1'b0;

   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [W-1:0] rsp_extent_offset;
   logic [W-1:0] rsp_extent_length;
   logic         rsp_last_of_item;

   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [cef_pkg::MIN_RUN_WIDTH-1:0] csr_min_run_length = '0;

   // stimulus and expectation stores
   byte_pair_type     pending_pairs[$];
   extent_record_type expected_extents[$];

   // predictor state
   logic [cef_pkg::MIN_RUN_WIDTH-1:0] min_run_cfg = cef_pkg::MIN_RUN_RESET;
   logic [W-1:0] scan_position = '0;
   logic         run_active = 1'b0;
   logic [W-1:0] run_begin = '0;
   logic         tail_active = 1'b0;
   logic [W-1:0] tail_begin = '0;

   // bookkeeping
   logic req_fired = 1'b0;
   bit   sender_gaps_on = 1'b1;
   bit   receiver_stalls_on = 1'b1;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   extents_seen = 0;
   int   extent_errors = 0;
   int   quiet_cycles = 0;

   changed_extent_finder_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_old_byte       (req_old_byte),
      .req_new_byte       (req_new_byte),
      .req_has_old        (req_has_old),
      .req_last_position  (req_last_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_extent_offset  (rsp_extent_offset),
      .rsp_extent_length  (rsp_extent_length),
      .rsp_last_of_item   (rsp_last_of_item),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_min_run_length (csr_min_run_length)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_pair(input logic [7:0] old_byte, input logic [7:0] new_byte,
                                    input logic has_old, input logic last_position);
      byte_pair_type bp;
      bp.old_byte = old_byte;
      bp.new_byte = new_byte;
      bp.has_old = has_old;
      bp.last_position = last_position;
      pending_pairs.push_back(bp);
   endfunction

   // one image: old data for a prefix, then a tail, with some noise mixed in
   function automatic int queue_random_image();
      int unsigned length;
      int unsigned old_len;
      int unsigned miss_pct;
      logic [7:0]  nb;
      logic [7:0]  ob;
      logic        has;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
      old_len = ($urandom_range(0, 99) < 55) ? length : $urandom_range(0, length);
      case ($urandom_range(0, 4))
         0: miss_pct = 2;
         1: miss_pct = 10;
         2: miss_pct = 30;
         3: miss_pct = 60;
         default: miss_pct = 90;
      endcase
      for (int i = 0; i < length; i++) begin
         nb = 8'($urandom_range(0, 255));
         if (i < old_len) begin
            has = ($urandom_range(0, 99) >= 3);
            ob = ($urandom_range(0, 99) < miss_pct) ? nb ^ 8'($urandom_range(1, 255)) : nb;
         end else begin
            // old data mostly stays gone, sometimes it reappears
            has = ($urandom_range(0, 99) < 15);
            ob = 8'($urandom_range(0, 255));
         end
         add_pair(ob, nb, has, i == length - 1);
      end
      return length;
   endfunction

   // extents caused by one accepted byte pair
   function automatic void predict_extents(input byte_pair_type bp);
      logic [W-1:0]      pos;
      logic [W-1:0]      span;
      extent_record_type found[$];
      pos = scan_position;
      if (bp.has_old && !tail_active) begin
         if (run_active) begin
            span = pos - run_begin;
            if (bp.old_byte == bp.new_byte && span >= W'(min_run_cfg)) begin
               found.push_back('{run_begin, span, 1'b0});
               run_active = 1'b0;
            end
         end else if (bp.old_byte != bp.new_byte) begin
            run_active = 1'b1;
            run_begin = pos;
         end
      end else begin
         // old data ended: close the run, open the tail
         if (run_active) begin
            found.push_back('{run_begin, pos - run_begin, 1'b0});
            run_active = 1'b0;
         end
         if (!tail_active) begin
            tail_active = 1'b1;
            tail_begin = pos;
         end
      end
      if (bp.last_position) begin
         if (run_active) found.push_back('{run_begin, pos + 1'b1 - run_begin, 1'b0});
         if (tail_active) found.push_back('{tail_begin, pos + 1'b1 - tail_begin, 1'b0});
         run_active = 1'b0;
         run_begin = '0;
         tail_active = 1'b0;
         tail_begin = '0;
         scan_position = '0;
      end else begin
         scan_position = pos + 1'b1;
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[k]) expected_extents.push_back(found[k]);
   endfunction

   // byte pair driver
   always @(negedge clock) begin : feed_byte_pairs
      byte_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            next_pair = pending_pairs.pop_front();
            req_old_byte <= next_pair.old_byte;
            req_new_byte <= next_pair.new_byte;
            req_has_old <= next_pair.has_old;
            req_last_position <= next_pair.last_position;
            req_valid <= 1'b1;
            send_gap = sender_gaps_on ? random_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // extent receiver with random stalls and one long hold-off
   always @(negedge clock) begin : drain_extents
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && extents_seen >= 40 && pending_pairs.size() > 20) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (receiver_stalls_on) stall_left = random_gap();
      end
   end

   // monitor: predict on byte pairs, check on extents
   always @(posedge clock) begin : check_extents
      byte_pair_type     seen_pair;
      extent_record_type want;
      req_fired <= req_valid && req_ready;
      if (!reset) begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            min_run_cfg = csr_min_run_length;
            quiet_cycles = 0;
         end
         if (req_valid && req_ready) begin
            seen_pair.old_byte = req_old_byte;
            seen_pair.new_byte = req_new_byte;
            seen_pair.has_old = req_has_old;
            seen_pair.last_position = req_last_position;
            predict_extents(seen_pair);
            quiet_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            extents_seen++;
            if (expected_extents.size() == 0) begin
               $error("unexpected extent: offset %0d length %0d",
                      rsp_extent_offset, rsp_extent_length);
               extent_errors++;
            end else begin
               want = expected_extents.pop_front();
               if (rsp_extent_offset !== want.offset) begin
                  $error("extent_offset: expected %0d, got %0d", want.offset, rsp_extent_offset);
                  extent_errors++;
               end
               if (rsp_extent_length !== want.length) begin
                  $error("extent_length: expected %0d, got %0d", want.length, rsp_extent_length);
                  extent_errors++;
               end
               if (rsp_last_of_item !== want.last) begin
                  $error("last_of_item: expected %0b, got %0b", want.last, rsp_last_of_item);
                  extent_errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // idle: everything sent and answered, then a further wait so items without extents settle
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_extents.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_min_run(input logic [cef_pkg::MIN_RUN_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_min_run_length <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // test sequence
   initial begin : run_test
      logic [cef_pkg::MIN_RUN_WIDTH-1:0] min_run_settings[6];
      int added;
      min_run_settings = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd512, 16'd0};
      min_run_settings[5] = cef_pkg::MIN_RUN_WIDTH'($urandom_range(2, 12));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed images at the reset run length
      add_pair(8'h00, 8'h00, 1'b1, 1'b1);
      add_pair(8'hFF, 8'h00, 1'b1, 1'b1);
      add_pair(8'h00, 8'h00, 1'b0, 1'b1);
      // run stays open through matches, closes at end of old data,
      // old data returning after the tail is ignored
      add_pair(8'h55, 8'hAA, 1'b1, 1'b0);
      add_pair(8'hAA, 8'hAA, 1'b1, 1'b0);
      add_pair(8'hFF, 8'hFF, 1'b1, 1'b0);
      add_pair(8'h00, 8'hFF, 1'b0, 1'b0);
      add_pair(8'h12, 8'h12, 1'b1, 1'b0);
      add_pair(8'h34, 8'h56, 1'b1, 1'b1);
      // run and tail both emitted on the final byte
      add_pair(8'h01, 8'h02, 1'b1, 1'b0);
      add_pair(8'h80, 8'h7F, 1'b1, 1'b0);
      add_pair(8'h00, 8'hFF, 1'b0, 1'b1);
      // last byte with the run open counts that byte
      add_pair(8'hFF, 8'hFE, 1'b1, 1'b0);
      add_pair(8'h00, 8'h00, 1'b1, 1'b1);
      // tail only, after a matching byte
      add_pair(8'hAA, 8'hAA, 1'b1, 1'b0);
      add_pair(8'hFF, 8'h00, 1'b0, 1'b0);
      add_pair(8'h00, 8'hFF, 1'b0, 1'b1);

      // random images under several run lengths
      foreach (min_run_settings[s]) begin
         wait_quiet();
         write_min_run(min_run_settings[s]);
         @(posedge clock);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         receiver_stalls_on = ($urandom_range(0, 3) != 0);
         added = 0;
         while (added < 72) added += queue_random_image();
      end

      wait_quiet();
      if (extent_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
